// ===== src/csds_pkg.sv =====
// Shared types and constants of the C-SCAN seek scheduler.
package csds_pkg;

    // Field widths
    localparam int TRACK_W = 12;
    localparam int SEEK_W  = 14;
    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    // Request store sizing
    localparam int MAX_REQ = 32;
    localparam int IDX_W   = $clog2(MAX_REQ);
    localparam int CNT_W   = $clog2(MAX_REQ + 1);

    // Front-to-back queue sizing
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [TRACK_W-1:0] DMAX_RESET = 12'd199;

    // Register indexes (byte address / 4)
    typedef enum logic [PADDR_W-3:0] {
        REG_HEAD  = 2'd0,
        REG_SWEEP = 2'd1,
        REG_DMAX  = 2'd2
    } t_reg_idx;

    // Classified request passed from the front to the back
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               store;
        logic               last;
    } t_req_entry;

    // Configuration seen by the scheduler
    typedef struct packed {
        logic [TRACK_W-1:0] head;
        logic               sweep_up;
        logic [TRACK_W-1:0] disk_max;
    } t_cfg;

endpackage

// ===== src/csds_if.sv =====
// Valid/ready channel interfaces for requests and service results.
interface csds_req_if;
    logic                        valid;
    logic                        ready;
    logic [csds_pkg::TRACK_W-1:0] track;
    logic                        batch_end;

    modport source (output valid, output track, output batch_end, input ready);
    modport sink   (input valid, input track, input batch_end, output ready);
endinterface

interface csds_svc_if;
    logic                        valid;
    logic                        ready;
    logic [csds_pkg::TRACK_W-1:0] served_track;
    logic [csds_pkg::SEEK_W-1:0]  seek_total;
    logic                        sequence_end;

    modport source (output valid, output served_track, output seek_total,
                    output sequence_end, input ready);
    modport sink   (input valid, input served_track, input seek_total,
                    input sequence_end, output ready);
endinterface

// ===== src/cscan_disk_seek_scheduler.sv =====
// Top level of the C-SCAN disk seek scheduler with its register port.
//
//  Channel   Direction  Handshake          Payload
//  i_req     in         valid/ready        track, batch_end
//  o_svc     out        valid/ready        served_track, seek_total, sequence_end
//  APB       in/out     psel/penable       head_track, sweep_up, disk_max
//
//  Requests enter one per cycle, while the queue has space, into a 4-entry queue;
//  the scheduler moves one queued request per cycle into its sorted store. After the
//  batch end it emits one result per cycle while o_svc is ready: n + 3 results for
//  n stored requests; the queue fills and i_req stalls during that walk.
//  Synchronous active-low reset clears counts, queue and the result register.
module cscan_disk_seek_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    csds_req_if.sink                     i_req,
    csds_svc_if.source                   o_svc,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csds_pkg::PADDR_W-1:0] paddr,
    input  logic [csds_pkg::PDATA_W-1:0] pwdata,
    output logic [csds_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic [csds_pkg::TRACK_W-1:0] r_head;
    logic                         r_sweep;
    logic [csds_pkg::TRACK_W-1:0] r_dmax;
    logic [csds_pkg::PADDR_W-3:0] reg_idx;
    logic                         wr_en;

    csds_pkg::t_cfg       cfg;
    csds_pkg::t_req_entry push_entry;
    csds_pkg::t_req_entry pop_entry;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[csds_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_sweep <= 1'b1;
            r_dmax  <= csds_pkg::DMAX_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                csds_pkg::REG_HEAD:  r_head  <= pwdata[csds_pkg::TRACK_W-1:0];
                csds_pkg::REG_SWEEP: r_sweep <= pwdata[0];
                csds_pkg::REG_DMAX:  r_dmax  <= pwdata[csds_pkg::TRACK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            csds_pkg::REG_HEAD:  prdata = csds_pkg::PDATA_W'(r_head);
            csds_pkg::REG_SWEEP: prdata = csds_pkg::PDATA_W'(r_sweep);
            csds_pkg::REG_DMAX:  prdata = csds_pkg::PDATA_W'(r_dmax);
            default:             prdata = '0;
        endcase
    end

    // Clamp the head to the last cylinder
    assign cfg.head     = (r_head > r_dmax) ? r_dmax : r_head;
    assign cfg.sweep_up = r_sweep;
    assign cfg.disk_max = r_dmax;

    csds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_disk_max (r_dmax),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    csds_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_entry),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_entry),
        .o_empty     (empty)
    );

    csds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_entry (pop_entry),
        .o_pop   (pop),
        .o_svc   (o_svc)
    );

endmodule

// ===== src/csds_front.sv =====
// Request front end: clamps, counts and classifies incoming requests.
module csds_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    csds_req_if.sink                     i_req,
    input  logic [csds_pkg::TRACK_W-1:0] i_disk_max,
    input  logic                         i_full,
    output logic                         o_push,
    output csds_pkg::t_req_entry         o_entry
);

    logic [csds_pkg::CNT_W-1:0] r_fcnt;
    logic [csds_pkg::CNT_W-1:0] n_fcnt;
    logic                       accept;
    logic                       room;

    // Take a transaction whenever the queue has space
    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign room        = r_fcnt < csds_pkg::CNT_W'(csds_pkg::MAX_REQ);

    // Classify: clamp the track, drop requests past a full store
    always_comb begin
        o_entry.track = (i_req.track > i_disk_max) ? i_disk_max : i_req.track;
        o_entry.store = room;
        o_entry.last  = i_req.batch_end;
        o_push        = accept && (room || i_req.batch_end);
        n_fcnt        = r_fcnt;
        if (accept) begin
            if (i_req.batch_end) begin
                n_fcnt = '0;
            end else if (room) begin
                n_fcnt = r_fcnt + 1'b1;
            end
        end
    end

    // Hold the per-batch request count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
        end else begin
            r_fcnt <= n_fcnt;
        end
    end

endmodule

// ===== src/csds_fifo.sv =====
// Short queue between the request front end and the scheduler.
module csds_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  csds_pkg::t_req_entry i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output csds_pkg::t_req_entry o_pop_data,
    output logic                 o_empty
);

    csds_pkg::t_req_entry         r_mem [csds_pkg::QDEPTH];
    logic [csds_pkg::QAW-1:0]     r_wr;
    logic [csds_pkg::QAW-1:0]     r_rd;
    logic [csds_pkg::QCW-1:0]     r_cnt;
    logic                         do_push;
    logic                         do_pop;

    assign o_full     = r_cnt == csds_pkg::QCW'(csds_pkg::QDEPTH);
    assign o_empty    = r_cnt == '0;
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/csds_back.sv =====
// Scheduler back end: sorted request store, C-SCAN walk and result register.
module csds_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csds_pkg::t_cfg       i_cfg,
    input  logic                 i_empty,
    input  csds_pkg::t_req_entry i_entry,
    output logic                 o_pop,
    csds_svc_if.source           o_svc
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_HEAD,
        S_UP,
        S_BND,
        S_WRAP,
        S_LOW_UP,
        S_LOW_DN,
        S_ZERO,
        S_UP_DN,
        S_ZERO2
    } t_state;

    localparam int TW = csds_pkg::TRACK_W;
    localparam int CW = csds_pkg::CNT_W;
    localparam int IW = csds_pkg::IDX_W;
    localparam int SW = csds_pkg::SEEK_W;
    localparam int NR = csds_pkg::MAX_REQ;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lo_cnt, n_lo_cnt;
    logic [TW-1:0]   r_prev, n_prev;
    logic [SW-1:0]   r_acc, n_acc;
    logic [TW-1:0]   r_cell [NR];
    logic [NR-1:0]   gt;

    logic            r_out_valid;
    logic [TW-1:0]   r_out_track;
    logic [SW-1:0]   r_out_seek;
    logic            r_out_end;

    logic            out_free;
    logic            emit_go;
    logic            emit_end;
    logic [TW-1:0]   emit_trk;
    logic [TW-1:0]   seek_dist;
    logic [SW:0]     seek_sum;
    logic [SW-1:0]   seek_sat;
    logic            ins;
    logic [TW-1:0]   cur_cell;
    logic [TW-1:0]   h;
    logic [TW-1:0]   dmax;
    logic            up;
    logic            h_nz;

    assign h        = i_cfg.head;
    assign dmax     = i_cfg.disk_max;
    assign up       = i_cfg.sweep_up;
    assign h_nz     = h != '0;
    assign out_free = !r_out_valid || o_svc.ready;
    assign cur_cell = r_cell[r_idx];

    // Insertion compare: cells past the fill count act as infinitely large
    always_comb begin
        for (int i = 0; i < NR; i++) begin
            gt[i] = (CW'(i) >= r_count) || (r_cell[i] > i_entry.track);
        end
    end

    // Shift larger cells up one place and drop the new track into the gap
    for (genvar g = 0; g < NR; g++) begin : g_cell
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (ins && gt[g]) begin
                    r_cell[g] <= i_entry.track;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (ins && gt[g]) begin
                    r_cell[g] <= gt[g-1] ? r_cell[g-1] : i_entry.track;
                end
            end
        end
    end

    // Seek distance of the next visited track, saturating running total
    assign seek_dist = (emit_trk > r_prev) ? emit_trk - r_prev : r_prev - emit_trk;
    assign seek_sum  = {1'b0, r_acc} + (SW + 1)'(seek_dist);
    assign seek_sat  = (seek_sum > (SW + 1)'(csds_pkg::SEEK_MAX)) ? csds_pkg::SEEK_MAX
                                                                  : seek_sum[SW-1:0];

    // Load the store, then walk the C-SCAN order one result at a time
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_lo_cnt = r_lo_cnt;
        n_prev   = r_prev;
        n_acc    = r_acc;
        o_pop    = 1'b0;
        ins      = 1'b0;
        emit_go  = 1'b0;
        emit_end = 1'b0;
        emit_trk = '0;

        case (r_state)
            S_LOAD: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_entry.store) begin
                        ins     = 1'b1;
                        n_count = r_count + 1'b1;
                        if (i_entry.track < h) begin
                            n_lo_cnt = r_lo_cnt + 1'b1;
                        end
                    end
                    if (i_entry.last) begin
                        n_state = S_HEAD;
                        n_prev  = h;
                    end
                end
            end
            default: begin
                emit_go = out_free;
            end
        endcase

        if (emit_go) begin
            case (r_state)
                S_HEAD: begin
                    emit_trk = h;
                    if (up) begin
                        if (r_lo_cnt < r_count) begin
                            n_state = S_UP;
                            n_idx   = IW'(r_lo_cnt);
                        end else begin
                            n_state = S_BND;
                        end
                    end else if (r_lo_cnt != '0) begin
                        n_state = S_LOW_DN;
                        n_idx   = IW'(r_lo_cnt - 1'b1);
                    end else begin
                        n_state = h_nz ? S_ZERO : S_WRAP;
                    end
                end
                S_UP: begin
                    emit_trk = cur_cell;
                    if (CW'(r_idx) == r_count - 1'b1) begin
                        n_state = S_BND;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                S_BND: begin
                    emit_trk = dmax;
                    n_state  = S_WRAP;
                end
                S_WRAP: begin
                    if (up) begin
                        emit_trk = '0;
                        emit_end = r_lo_cnt == '0;
                        n_state  = S_LOW_UP;
                        n_idx    = '0;
                    end else begin
                        emit_trk = dmax;
                        if (r_count > r_lo_cnt) begin
                            n_state = S_UP_DN;
                            n_idx   = IW'(r_count - 1'b1);
                        end else if (!h_nz) begin
                            n_state = S_ZERO2;
                        end else begin
                            emit_end = 1'b1;
                        end
                    end
                end
                S_LOW_UP: begin
                    emit_trk = cur_cell;
                    emit_end = CW'(r_idx) == r_lo_cnt - 1'b1;
                    n_idx    = r_idx + 1'b1;
                end
                S_LOW_DN: begin
                    emit_trk = cur_cell;
                    if (r_idx == '0) begin
                        n_state = h_nz ? S_ZERO : S_WRAP;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
                S_ZERO: begin
                    emit_trk = '0;
                    n_state  = S_WRAP;
                end
                S_UP_DN: begin
                    emit_trk = cur_cell;
                    if (CW'(r_idx) == r_lo_cnt) begin
                        if (h_nz) begin
                            emit_end = 1'b1;
                        end else begin
                            n_state = S_ZERO2;
                        end
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
                S_ZERO2: begin
                    emit_trk = '0;
                    emit_end = 1'b1;
                end
                default: begin
                    emit_trk = '0;
                end
            endcase

            n_prev = emit_trk;
            n_acc  = seek_sat;
            if (emit_end) begin
                n_state  = S_LOAD;
                n_idx    = '0;
                n_count  = '0;
                n_lo_cnt = '0;
                n_acc    = '0;
            end
        end
    end

    // Hold walk state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_idx       <= '0;
            r_count     <= '0;
            r_lo_cnt    <= '0;
            r_prev      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_out_track <= '0;
            r_out_seek  <= '0;
            r_out_end   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_lo_cnt <= n_lo_cnt;
            r_prev   <= n_prev;
            r_acc    <= n_acc;
            if (emit_go) begin
                r_out_valid <= 1'b1;
                r_out_track <= emit_trk;
                r_out_seek  <= seek_sat;
                r_out_end   <= emit_end;
            end else if (o_svc.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_svc.valid        = r_out_valid;
    assign o_svc.served_track = r_out_track;
    assign o_svc.seek_total   = r_out_seek;
    assign o_svc.sequence_end = r_out_end;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NR))
        else $error("request count above store depth");

    a_lo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo_cnt <= r_count)
        else $error("below-head count exceeds request count");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_acc == '0))
        else $error("seek total not cleared between batches");

    a_end_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && emit_end) |=> (r_state == S_LOAD && r_out_valid && r_out_end))
        else $error("batch end not marked on final result");

    a_no_pop_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_pop)
        else $error("queue popped during service walk");

endmodule

// ===== test/tb_cscan_disk_seek_scheduler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the C-SCAN seek scheduler: directed rows, then random batches.
module tb_cscan_disk_seek_scheduler;

    typedef struct packed {
        logic [csds_pkg::TRACK_W-1:0] served_track;
        logic [csds_pkg::SEEK_W-1:0]  seek_total;
        logic                         sequence_end;
    } t_visit;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // One row of directed stimulus: a request or a register write
    typedef struct packed {
        t_row_kind                    kind;
        csds_pkg::t_reg_idx           regsel;
        logic [csds_pkg::TRACK_W-1:0] value;
        logic                         last;
        logic                         typed;
    } t_row;

    localparam int N_ROWS     = 30;
    localparam int HOLD_CYC   = 300;
    localparam int SETTLE_CYC = 8;
    localparam int N_RANDOM   = 198;

    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // reset settings: head 0, upward, boundary 199
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd0,    1'b1, 1'b1},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd4095, 1'b1, 1'b1},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd150,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd10,   1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd199,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd60,   1'b1, 1'b0},
        // requests equal to the head, upward then downward
        '{ROW_CFG, csds_pkg::REG_HEAD,  12'd100,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd30,   1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd100,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd170,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd100,  1'b1, 1'b0},
        '{ROW_CFG, csds_pkg::REG_SWEEP, 12'd0,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd30,   1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd100,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd170,  1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd100,  1'b1, 1'b0},
        // head above the boundary gets clamped
        '{ROW_CFG, csds_pkg::REG_HEAD,  12'd4095, 1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd5,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd4095, 1'b1, 1'b0},
        // widest disk, upward from the top cylinder
        '{ROW_CFG, csds_pkg::REG_DMAX,  12'd4095, 1'b0, 1'b0},
        '{ROW_CFG, csds_pkg::REG_SWEEP, 12'd1,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd4095, 1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd0,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd2048, 1'b1, 1'b0},
        // narrowest disk, both directions
        '{ROW_CFG, csds_pkg::REG_DMAX,  12'd1,    1'b0, 1'b0},
        '{ROW_CFG, csds_pkg::REG_HEAD,  12'd0,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd1,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd3000, 1'b1, 1'b0},
        '{ROW_CFG, csds_pkg::REG_SWEEP, 12'd0,    1'b0, 1'b0},
        '{ROW_REQ, csds_pkg::REG_HEAD,  12'd0,    1'b1, 1'b0}
    };

    // Hand-worked service orders of the first two directed batches
    localparam t_visit TYPED_VISITS [8] = '{
        '{12'd0,   14'd0,   1'b0},
        '{12'd0,   14'd0,   1'b0},
        '{12'd199, 14'd199, 1'b0},
        '{12'd0,   14'd398, 1'b1},
        '{12'd0,   14'd0,   1'b0},
        '{12'd199, 14'd199, 1'b0},
        '{12'd199, 14'd199, 1'b0},
        '{12'd0,   14'd398, 1'b1}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [csds_pkg::PADDR_W-1:0] paddr;
    logic [csds_pkg::PDATA_W-1:0] pwdata;
    logic [csds_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    csds_req_if req_ch ();
    csds_svc_if svc_ch ();

    cscan_disk_seek_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_svc   (svc_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Scheduler copy: settings, pending requests and expected service order
    logic [csds_pkg::TRACK_W-1:0] cfg_head     = '0;
    logic                         cfg_sweep_up = 1'b1;
    logic [csds_pkg::TRACK_W-1:0] cfg_disk_max = csds_pkg::DMAX_RESET;
    logic [csds_pkg::TRACK_W-1:0] stored_tracks [$];
    t_visit                       batch_plan [$];
    t_visit                       expected_visits [$];
    t_visit                       next_visit;
    int                           typed_idx   = 0;
    int                           idle_pct    = 16;
    bit                           long_hold   = 1'b0;
    int                           error_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Work out the C-SCAN visit order and running seek of the stored batch
    function automatic void plan_batch();
        logic [csds_pkg::TRACK_W-1:0] cyl [$];
        logic [csds_pkg::TRACK_W-1:0] route [$];
        logic [csds_pkg::TRACK_W-1:0] head;
        logic [csds_pkg::TRACK_W-1:0] prev;
        logic [csds_pkg::TRACK_W-1:0] key;
        int                           pos;
        int                           wrap_at;
        int                           seek;
        int                           move;
        int                           j;
        t_visit                       v;
        head = (cfg_head > cfg_disk_max) ? cfg_disk_max : cfg_head;
        cyl = stored_tracks;
        cyl.push_back(head);
        cyl.push_back(cfg_sweep_up ? cfg_disk_max : '0);
        // stable insertion sort, head lands after equal requests
        for (int i = 1; i < cyl.size(); i++) begin
            key = cyl[i];
            j = i;
            while (j > 0 && cyl[j-1] > key) begin
                cyl[j] = cyl[j-1];
                j--;
            end
            cyl[j] = key;
        end
        pos = 0;
        foreach (cyl[i]) if (cyl[i] < head) pos++;
        if (cfg_sweep_up) begin
            for (int i = pos; i < cyl.size(); i++) route.push_back(cyl[i]);
            wrap_at = route.size();
            route.push_back('0);
            for (int i = 0; i < pos; i++) route.push_back(cyl[i]);
        end else begin
            for (int i = pos; i >= 0; i--) route.push_back(cyl[i]);
            wrap_at = route.size();
            route.push_back(cfg_disk_max);
            for (int i = cyl.size() - 1; i > pos; i--) route.push_back(cyl[i]);
        end
        // accumulate movement; the wrap jump costs the full disk span
        prev = head;
        seek = 0;
        foreach (route[i]) begin
            if (i == wrap_at)
                move = int'(cfg_disk_max);
            else
                move = (route[i] > prev) ? int'(route[i] - prev) : int'(prev - route[i]);
            seek = seek + move;
            if (seek > int'(csds_pkg::SEEK_MAX)) seek = int'(csds_pkg::SEEK_MAX);
            prev = route[i];
            v.served_track = route[i];
            v.seek_total   = seek[csds_pkg::SEEK_W-1:0];
            v.sequence_end = (i == route.size() - 1);
            batch_plan.push_back(v);
        end
    endfunction

    // Offer one request, hold it until accepted, then update the prediction
    task automatic send_req(input logic [csds_pkg::TRACK_W-1:0] trk, input logic last,
                            input logic typed);
        logic [csds_pkg::TRACK_W-1:0] kept;
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid     <= 1'b1;
        req_ch.track     <= trk;
        req_ch.batch_end <= last;
        do @(posedge i_clk); while (!req_ch.ready);
        kept = (trk > cfg_disk_max) ? cfg_disk_max : trk;
        if (stored_tracks.size() < csds_pkg::MAX_REQ) stored_tracks.push_back(kept);
        if (last) begin
            plan_batch();
            foreach (batch_plan[i]) begin
                if (typed) begin
                    expected_visits.push_back(TYPED_VISITS[typed_idx]);
                    typed_idx++;
                end else begin
                    expected_visits.push_back(batch_plan[i]);
                end
            end
            batch_plan.delete();
            stored_tracks.delete();
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_visits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Register write: setup phase, access phase, then psel drops before returning
    task automatic write_reg(input csds_pkg::t_reg_idx idx,
                             input logic [csds_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            csds_pkg::REG_HEAD:  cfg_head     = value[csds_pkg::TRACK_W-1:0];
            csds_pkg::REG_SWEEP: cfg_sweep_up = value[0];
            csds_pkg::REG_DMAX:  cfg_disk_max = value[csds_pkg::TRACK_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [csds_pkg::TRACK_W-1:0] dmax;
        case ($urandom_range(3))
            0:       dmax = 12'd1;
            1:       dmax = 12'd4095;
            2:       dmax = csds_pkg::DMAX_RESET;
            default: dmax = csds_pkg::TRACK_W'($urandom_range(4095, 1));
        endcase
        write_reg(csds_pkg::REG_DMAX, csds_pkg::PDATA_W'(dmax));
        write_reg(csds_pkg::REG_SWEEP, $urandom_range(1));
        write_reg(csds_pkg::REG_HEAD,
                  $urandom_range(1) ? $urandom_range(dmax) : $urandom_range(4095));
    endtask

    function automatic logic [csds_pkg::TRACK_W-1:0] random_track();
        case ($urandom_range(9))
            0:          return cfg_head;
            1, 2, 3, 4: return csds_pkg::TRACK_W'($urandom_range(cfg_disk_max));
            default:    return csds_pkg::TRACK_W'($urandom_range(4095));
        endcase
    endfunction

    // Result side: random back-pressure plus one long hold-off on request
    initial begin
        int held;
        svc_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                svc_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYC; held++) @(posedge i_clk);
                long_hold = 1'b0;
            end
            svc_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && svc_ch.valid && svc_ch.ready) begin
            if (expected_visits.size() == 0) begin
                $error("unexpected result: served_track %0d seek_total %0d",
                       svc_ch.served_track, svc_ch.seek_total);
                error_count++;
            end else begin
                next_visit = expected_visits.pop_front();
                if (svc_ch.served_track !== next_visit.served_track) begin
                    $error("served_track: expected %0d, got %0d",
                           next_visit.served_track, svc_ch.served_track);
                    error_count++;
                end
                if (svc_ch.seek_total !== next_visit.seek_total) begin
                    $error("seek_total: expected %0d, got %0d",
                           next_visit.seek_total, svc_ch.seek_total);
                    error_count++;
                end
                if (svc_ch.sequence_end !== next_visit.sequence_end) begin
                    $error("sequence_end: expected %0b, got %0b",
                           next_visit.sequence_end, svc_ch.sequence_end);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed rows, then random batches
    initial begin
        int   sent;
        int   batch_no;
        int   n_req;
        t_row row;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.track     = '0;
        req_ch.batch_end = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.regsel, csds_pkg::PDATA_W'(row.value));
            end else begin
                send_req(row.value, row.last, row.typed);
            end
        end

        sent = 0;
        batch_no = 0;
        while (sent < N_RANDOM) begin
            // reconfigure between batches every third batch
            if (batch_no % 3 == 0) begin
                wait_idle();
                random_config();
            end
            // pause the sender until the block has drained
            if (batch_no == 13) wait_idle();
            idle_pct = (batch_no >= 14 && batch_no < 22) ? 0 : 16;
            case ($urandom_range(19))
                0:       n_req = $urandom_range(40, 33);
                1, 2:    n_req = $urandom_range(32, 9);
                default: n_req = $urandom_range(8, 1);
            endcase
            // hold off results while two 12-request batches keep coming
            if (batch_no == 4) begin
                n_req = 12;
                long_hold = 1'b1;
            end
            if (batch_no == 5) n_req = 12;
            if (batch_no == 10) n_req = 36;
            for (int k = 0; k < n_req; k++)
                send_req(random_track(), k == n_req - 1, 1'b0);
            sent += n_req;
            batch_no++;
        end

        req_ch.valid <= 1'b0;
        while (expected_visits.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== cscan_disk_seek_scheduler.f =====
src/csds_pkg.sv
src/csds_if.sv
src/csds_front.sv
src/csds_fifo.sv
src/csds_back.sv
src/cscan_disk_seek_scheduler.sv
test/tb_cscan_disk_seek_scheduler.sv
